[rtl/accb_pkg.sv]
// Shared types, constants and helpers for the acceleration bands core.
// Depends on nothing; used by every module in rtl/.
`default_nettype none

package accb_pkg;

	localparam int PRICE_W   = 32;                  // Q16.16 price word
	localparam int PERIOD_W  = 7;                   // period register width
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd20;
	localparam int PERIOD_MIN = 2;

	localparam int FRAC_SH   = 16;                  // Q.16 fraction bits
	localparam int FACTOR_SH = FRAC_SH + 2;         // 4 * 2^16 on the factor numerator

	// Shared divider: dividend is wide enough for the factor numerator plus rounding
	localparam int FDW = 51;                        // dividend / quotient width
	localparam int DSW = PRICE_W + 1;               // divisor width (|high+low| <= 2^32)
	localparam int STW = $clog2(FDW + 1);           // step counter width

	// Split multiplier: 32 x 26 per pass, two passes per product
	localparam int MUL_AW  = PRICE_W;
	localparam int MUL_BW  = 26;
	localparam int MUL_PW  = MUL_AW + MUL_BW;
	localparam int PROD_W  = MUL_PW + MUL_BW;       // full |x| * |f| magnitude
	localparam int PROD_OK = 63;                    // products at or above 2^63 saturate
	localparam int RND_W   = PROD_OK - FRAC_SH + 1; // rounded scale magnitude
	localparam int TERM_W  = RND_W + 2;             // price plus scale, signed
	localparam logic [RND_W-1:0] SCALE_OVF = RND_W'(64'd1 << 40);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FDIV,
		ST_FWAIT,
		ST_MUL,
		ST_TERMS,
		ST_ADIV,
		ST_AWAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		AVG_UP,
		AVG_MID,
		AVG_LOW
	} avg_sel_t;

	typedef struct packed {
		logic                 start;
		logic [FDW-1:0]       dividend;
		logic [DSW-1:0]       divisor;
		logic [STW-1:0]       steps;
	} div_req_t;

	typedef struct packed {
		logic signed [PRICE_W-1:0] up;
		logic signed [PRICE_W-1:0] lo;
		logic signed [PRICE_W-1:0] cl;
	} ring_entry_t;

	function automatic logic signed [PRICE_W-1:0] sat32(input logic signed [63:0] x);
		logic signed [PRICE_W-1:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[PRICE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/accb_div.sv]
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// Depends on accb_pkg (div_req_t, widths). Dividend is MSB-aligned by the caller.
`default_nettype none

module accb_div
	import accb_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire div_req_t       req,
	output logic                done,
	output logic [FDW-1:0]      quotient
);

	logic [DSW-1:0] rem_q;
	logic [FDW-1:0] dq_q;
	logic [STW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [DSW:0]   rem_sh;
	logic [DSW+1:0] trial;

	assign rem_sh = {rem_q, dq_q[FDW-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STW'(1);
				if (cnt_q == STW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Divisor must stay on req.divisor for the whole run
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
		end else if (busy_q) begin
			if (!trial[DSW+1]) begin
				rem_q <= trial[DSW-1:0];
				dq_q  <= {dq_q[FDW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DSW-1:0];
				dq_q  <= {dq_q[FDW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

[rtl/accb_mul.sv]
// Registered 32 x 26 unsigned multiplier, one pass of the split factor product.
// Depends on accb_pkg (multiplier widths).
`default_nettype none

module accb_mul
	import accb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [MUL_AW-1:0] a,
	input  wire logic [MUL_BW-1:0] b,
	output logic      [MUL_PW-1:0] p
);

	logic [MUL_PW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_PW'(a) * MUL_PW'(b);
	end

	assign p = p_q;

endmodule

`default_nettype wire

[rtl/accb_ring.sv]
// Ring store of upper, lower and close terms: one synchronous memory,
// one read and one write port, registered read data. Depends on accb_pkg.
`default_nettype none

module accb_ring
	import accb_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
)(
	input  wire logic        clk,
	input  wire logic        rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output ring_entry_t      rd_data,
	input  wire logic        wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire ring_entry_t wr_data
);

	ring_entry_t mem_q [DEPTH];
	ring_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[rtl/acceleration_bands_core.sv]
// Acceleration bands core: one bar in, upper/middle/lower band averages out.
// States per bar: IDLE, FDIV, FWAIT, MUL, TERMS, then ADIV and AWAIT for each average, then EMIT.
// The shared one-bit-per-cycle divider gives FDW = 51 factor quotient bits and SW bits per average
// (SW = 38 at MAX_PERIOD = 64). One bar at a time: the next waits for IDLE and any output stall.
// A bar with high+low == 0 skips the factor division and multiply; a warm-up bar ends after the
// term update. Reset clears period to 20 and empties the window; no ring clear pass.
`default_nettype none

module acceleration_bands_core
	import accb_pkg::*;
#(
	parameter int MAX_PERIOD = 64
)(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       period_we,
	input  wire logic [PERIOD_W-1:0]        period_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [PRICE_W-1:0]  bar_high,
	input  wire logic signed [PRICE_W-1:0]  bar_low,
	input  wire logic signed [PRICE_W-1:0]  bar_close,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [PRICE_W-1:0]       upper_band,
	output logic signed [PRICE_W-1:0]       middle_band,
	output logic signed [PRICE_W-1:0]       lower_band
);

	localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
	localparam int SW = PRICE_W + $clog2(MAX_PERIOD);

	state_t   state_q, state_d;
	avg_sel_t k_q;

	logic signed [PRICE_W-1:0] h_q, l_q, c_q;
	logic [FDW-1:0]            mf_q;
	logic                      f_neg_q;
	logic [2:0]                mcnt_q;
	logic [PROD_W-1:0]         ph_q, pl_q;
	logic signed [SW-1:0]      sum_u_q, sum_m_q, sum_l_q;
	logic [AW-1:0]             slot_q;
	logic [PERIOD_W-1:0]       fill_q, period_q, act_p;
	logic signed [PRICE_W-1:0] res_u_q, res_m_q, res_l_q;
	logic                      out_valid_q;
	logic signed [PRICE_W-1:0] upper_q, middle_q, lower_q;

	// control from the state machine
	logic     accept, mem_wr, emit;
	div_req_t div_req;
	logic     div_done;
	logic [FDW-1:0] div_quo;
	ring_entry_t old_e, new_e;

	// ---------------- active period ----------------
	always_comb begin
		if (period_q < PERIOD_W'(PERIOD_MIN)) begin
			act_p = PERIOD_W'(PERIOD_MIN);
		end else if (int'(period_q) > MAX_PERIOD) begin
			act_p = PERIOD_W'(MAX_PERIOD);
		end else begin
			act_p = period_q;
		end
	end

	// ---------------- band factor operands ----------------
	logic signed [PRICE_W:0] sum_hl, dif_hl;
	logic [PRICE_W:0]        ms, md;
	logic                    cancel;
	logic [FDW-1:0]          f_dividend;

	assign sum_hl     = {h_q[PRICE_W-1], h_q} + {l_q[PRICE_W-1], l_q};
	assign dif_hl     = {h_q[PRICE_W-1], h_q} - {l_q[PRICE_W-1], l_q};
	assign ms         = sum_hl[PRICE_W] ? -sum_hl : sum_hl;
	assign md         = dif_hl[PRICE_W] ? -dif_hl : dif_hl;
	assign cancel     = (sum_hl == '0);
	assign f_dividend = FDW'({md, {FACTOR_SH{1'b0}}}) + FDW'(ms >> 1);

	// ---------------- split multiply ----------------
	logic [MUL_AW-1:0] mh, ml, mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_p;

	assign mh    = h_q[PRICE_W-1] ? MUL_AW'(-h_q) : MUL_AW'(h_q);
	assign ml    = l_q[PRICE_W-1] ? MUL_AW'(-l_q) : MUL_AW'(l_q);
	assign mul_a = mcnt_q[1] ? ml : mh;
	assign mul_b = mcnt_q[0] ? MUL_BW'(mf_q[FDW-1:MUL_BW]) : mf_q[MUL_BW-1:0];

	accb_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// ---------------- term assembly ----------------
	logic [63:0]               rnd_h_w, rnd_l_w;
	logic [RND_W-1:0]          r_h, r_l;
	logic [TERM_W-1:0]         r_hx, r_lx;
	logic signed [TERM_W-1:0]  up_w, lo_w;
	logic signed [PRICE_W-1:0] up_t, lo_t;

	assign rnd_h_w = {1'b0, ph_q[PROD_OK-1:0]} + 64'd32768;
	assign rnd_l_w = {1'b0, pl_q[PROD_OK-1:0]} + 64'd32768;
	assign r_h  = (|ph_q[PROD_W-1:PROD_OK]) ? SCALE_OVF : rnd_h_w[63:FRAC_SH];
	assign r_l  = (|pl_q[PROD_W-1:PROD_OK]) ? SCALE_OVF : rnd_l_w[63:FRAC_SH];
	assign r_hx = {2'b00, r_h};
	assign r_lx = {2'b00, r_l};

	assign up_w = {{(TERM_W-PRICE_W){h_q[PRICE_W-1]}}, h_q}
		+ ((h_q[PRICE_W-1] ^ f_neg_q) ? -r_hx : r_hx);
	assign lo_w = {{(TERM_W-PRICE_W){l_q[PRICE_W-1]}}, l_q}
		+ ((l_q[PRICE_W-1] ^ f_neg_q) ? r_lx : -r_lx);

	assign up_t = cancel ? h_q : sat32({{(64-TERM_W){up_w[TERM_W-1]}}, up_w});
	assign lo_t = cancel ? l_q : sat32({{(64-TERM_W){lo_w[TERM_W-1]}}, lo_w});

	assign new_e.up = up_t;
	assign new_e.lo = lo_t;
	assign new_e.cl = c_q;

	// ---------------- window update ----------------
	logic                 full;
	logic [PERIOD_W-1:0]  fill_d;
	logic [AW-1:0]        slot_d;
	logic signed [SW-1:0] sub_u, sub_m, sub_l;

	assign full   = (fill_q >= act_p);
	assign fill_d = full ? fill_q : fill_q + PERIOD_W'(1);
	assign slot_d = ((PERIOD_W'(slot_q) + PERIOD_W'(1)) == act_p) ? '0 : slot_q + AW'(1);
	assign sub_u  = full ? {{(SW-PRICE_W){old_e.up[PRICE_W-1]}}, old_e.up} : '0;
	assign sub_m  = full ? {{(SW-PRICE_W){old_e.cl[PRICE_W-1]}}, old_e.cl} : '0;
	assign sub_l  = full ? {{(SW-PRICE_W){old_e.lo[PRICE_W-1]}}, old_e.lo} : '0;

	accb_ring #(
		.DEPTH (MAX_PERIOD),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (slot_q),
		.rd_data (old_e),
		.wr_en   (mem_wr),
		.wr_addr (slot_q),
		.wr_data (new_e)
	);

	// ---------------- averages ----------------
	logic signed [SW-1:0]      sel_sum;
	logic [SW-1:0]             mag_a, mag_r;
	logic [FDW-1:0]            a_dividend;
	logic [63:0]               qx;
	logic signed [PRICE_W-1:0] a_res;

	always_comb begin
		case (k_q)
			AVG_UP:  sel_sum = sum_u_q;
			AVG_MID: sel_sum = sum_m_q;
			AVG_LOW: sel_sum = sum_l_q;
			default: sel_sum = sum_l_q;
		endcase
	end

	assign mag_a      = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
	assign mag_r      = mag_a + SW'(act_p >> 1);
	assign a_dividend = {mag_r, {(FDW-SW){1'b0}}};
	assign qx         = {{(64-SW){1'b0}}, div_quo[SW-1:0]};
	assign a_res      = sat32(sel_sum[SW-1] ? -qx : qx);

	accb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------- control ----------------
	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		mem_wr           = 1'b0;
		emit             = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = f_dividend;
		div_req.divisor  = ms;
		div_req.steps    = STW'(FDW);
		if (state_q == ST_ADIV || state_q == ST_AWAIT) begin
			div_req.dividend = a_dividend;
			div_req.divisor  = DSW'(act_p);
			div_req.steps    = STW'(SW);
		end
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_FDIV;
				end
			end
			ST_FDIV: begin
				if (cancel) begin
					state_d = ST_TERMS;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_FWAIT;
				end
			end
			ST_FWAIT: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mcnt_q == 3'd4) begin
					state_d = ST_TERMS;
				end
			end
			ST_TERMS: begin
				mem_wr  = 1'b1;
				state_d = (fill_d >= act_p) ? ST_ADIV : ST_IDLE;
			end
			ST_ADIV: begin
				div_req.start = 1'b1;
				state_d       = ST_AWAIT;
			end
			ST_AWAIT: begin
				if (div_done) begin
					state_d = (k_q == AVG_LOW) ? ST_EMIT : ST_ADIV;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window state and period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			sum_u_q  <= '0;
			sum_m_q  <= '0;
			sum_l_q  <= '0;
			slot_q   <= '0;
			fill_q   <= '0;
			k_q      <= AVG_UP;
			mcnt_q   <= '0;
		end else if (period_we) begin
			// a new period empties the window
			period_q <= period_wdata;
			sum_u_q  <= '0;
			sum_m_q  <= '0;
			sum_l_q  <= '0;
			slot_q   <= '0;
			fill_q   <= '0;
		end else begin
			if (state_q == ST_FWAIT) begin
				mcnt_q <= '0;
			end else if (state_q == ST_MUL) begin
				mcnt_q <= mcnt_q + 3'd1;
			end
			if (mem_wr) begin
				sum_u_q <= sum_u_q + {{(SW-PRICE_W){up_t[PRICE_W-1]}}, up_t} - sub_u;
				sum_m_q <= sum_m_q + {{(SW-PRICE_W){c_q[PRICE_W-1]}}, c_q} - sub_m;
				sum_l_q <= sum_l_q + {{(SW-PRICE_W){lo_t[PRICE_W-1]}}, lo_t} - sub_l;
				slot_q  <= slot_d;
				fill_q  <= fill_d;
				k_q     <= AVG_UP;
			end
			if (state_q == ST_AWAIT && div_done) begin
				case (k_q)
					AVG_UP:  k_q <= AVG_MID;
					AVG_MID: k_q <= AVG_LOW;
					default: k_q <= AVG_UP;
				endcase
			end
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			h_q <= bar_high;
			l_q <= bar_low;
			c_q <= bar_close;
		end
		if (state_q == ST_FWAIT && div_done) begin
			mf_q    <= div_quo;
			f_neg_q <= dif_hl[PRICE_W] ^ sum_hl[PRICE_W];
		end
		if (state_q == ST_MUL) begin
			case (mcnt_q)
				3'd1:    ph_q <= PROD_W'(mul_p);
				3'd2:    ph_q <= ph_q + (PROD_W'(mul_p) << MUL_BW);
				3'd3:    pl_q <= PROD_W'(mul_p);
				3'd4:    pl_q <= pl_q + (PROD_W'(mul_p) << MUL_BW);
				default: ph_q <= ph_q;
			endcase
		end
		if (state_q == ST_AWAIT && div_done) begin
			case (k_q)
				AVG_UP:  res_u_q <= a_res;
				AVG_MID: res_m_q <= a_res;
				default: res_l_q <= a_res;
			endcase
		end
		if (emit) begin
			upper_q  <= res_u_q;
			middle_q <= res_m_q;
			lower_q  <= res_l_q;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign upper_band  = upper_q;
	assign middle_band = middle_q;
	assign lower_band  = lower_q;

	// ---------------- assertions ----------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= act_p)
		else $error("window fill count beyond active period");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		PERIOD_W'(slot_q) < act_p)
		else $error("ring slot beyond active period");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_FWAIT || state_q == ST_AWAIT))
		else $error("divider finished while no division was pending");

	a_one_bar: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second word taken while a bar is in progress");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for acceleration_bands_core: bars in, band averages out.
// Depends on accb_pkg and the core; the band arithmetic is predicted in place.
`timescale 1ns / 1ps

module testbench;
	import accb_pkg::*;

	localparam int DEPTH        = 64;
	localparam int DRAIN_CYCLES = 250;
	localparam int PHASE_BARS   = 140;
	localparam int CYCLE_LIMIT  = 4_000_000;

	typedef struct packed {
		logic signed [PRICE_W-1:0] high;
		logic signed [PRICE_W-1:0] low;
		logic signed [PRICE_W-1:0] close;
	} bar_t;

	typedef struct packed {
		logic signed [PRICE_W-1:0] upper;
		logic signed [PRICE_W-1:0] middle;
		logic signed [PRICE_W-1:0] lower;
	} band_t;

	typedef enum int {
		RX_OPEN,
		RX_OPEN_LONG,
		RX_HOLD,
		RX_JITTER
	} rx_mode_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      period_we    = 1'b0;
	logic [PERIOD_W-1:0]       period_wdata = '0;
	logic                      in_valid     = 1'b0;
	logic                      in_ready;
	logic signed [PRICE_W-1:0] bar_high     = '0;
	logic signed [PRICE_W-1:0] bar_low      = '0;
	logic signed [PRICE_W-1:0] bar_close    = '0;
	logic                      out_valid;
	logic                      out_ready    = 1'b0;
	logic signed [PRICE_W-1:0] upper_band;
	logic signed [PRICE_W-1:0] middle_band;
	logic signed [PRICE_W-1:0] lower_band;

	acceleration_bands_core #(
		.MAX_PERIOD(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.period_we(period_we),
		.period_wdata(period_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.bar_high(bar_high),
		.bar_low(bar_low),
		.bar_close(bar_close),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.upper_band(upper_band),
		.middle_band(middle_band),
		.lower_band(lower_band)
	);

	// Predicted window state
	logic signed [PRICE_W-1:0] upper_ring [DEPTH];
	logic signed [PRICE_W-1:0] lower_ring [DEPTH];
	logic signed [PRICE_W-1:0] close_ring [DEPTH];
	longint upper_acc = 0;
	longint middle_acc = 0;
	longint lower_acc = 0;
	int     win_len  = PERIOD_RESET;
	int     win_slot = 0;
	int     win_fill = 0;

	bar_t  bar_queue [$];
	band_t band_queue [$];
	bar_t  sent_bar;
	band_t want_band;

	int mismatches    = 0;
	int bands_checked = 0;
	int bars_queued   = 0;
	int bars_taken    = 0;
	int settings_used = 1;
	int cycle_count   = 0;
	int burst_left    = 1;
	int gap_left      = 0;
	int stall_run     = 0;
	rx_mode_t stall_mode = RX_OPEN;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint unsigned abs_u64(input longint x);
		if (x < 0) return -x;
		return x;
	endfunction

	// Round to nearest, ties away from zero
	function automatic longint div_round(input longint n, input longint d);
		longint unsigned md, q;
		md = abs_u64(d);
		q = (abs_u64(n) + md / 2) / md;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// round(x * f / 2^16); a product magnitude of 2^63 or more maps to 2^40 so the term saturates
	function automatic longint factor_scale(input longint x, input longint f);
		longint unsigned mf;
		if (x == 0 || f == 0) return 0;
		mf = abs_u64(f);
		if (abs_u64(x) > 64'h7FFF_FFFF_FFFF_FFFF / mf)
			return ((x < 0) != (f < 0)) ? -(longint'(1) << 40) : (longint'(1) << 40);
		return div_round(x * f, 65536);
	endfunction

	function automatic logic signed [PRICE_W-1:0] clamp_price(input longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[PRICE_W-1:0];
	endfunction

	function automatic void advance_window(input bar_t b);
		longint h, l, s, f;
		logic signed [PRICE_W-1:0] up, lo;
		int slot;
		band_t res;
		h = b.high;
		l = b.low;
		s = h + l;
		slot = win_slot % win_len;
		if (s == 0) begin
			up = b.high;
			lo = b.low;
		end else begin
			f = div_round(4 * (h - l) * 65536, s);
			up = clamp_price(h + factor_scale(h, f));
			lo = clamp_price(l - factor_scale(l, f));
		end
		// drop the oldest bar once the window is full
		if (win_fill >= win_len) begin
			upper_acc -= upper_ring[slot];
			lower_acc -= lower_ring[slot];
			middle_acc -= close_ring[slot];
		end
		upper_ring[slot] = up;
		lower_ring[slot] = lo;
		close_ring[slot] = b.close;
		upper_acc += up;
		lower_acc += lo;
		middle_acc += b.close;
		win_slot = (slot + 1) % win_len;
		if (win_fill < win_len) win_fill++;
		if (win_fill < win_len) return;
		res.upper  = clamp_price(div_round(upper_acc, win_len));
		res.middle = clamp_price(div_round(middle_acc, win_len));
		res.lower  = clamp_price(div_round(lower_acc, win_len));
		band_queue.push_back(res);
	endfunction

	function automatic void check_field(input string label,
			input logic signed [PRICE_W-1:0] want, input logic signed [PRICE_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, label, want, got);
			mismatches++;
		end
	endfunction

	function automatic void push_bar(input logic signed [PRICE_W-1:0] h,
			input logic signed [PRICE_W-1:0] l, input logic signed [PRICE_W-1:0] c);
		bar_t b;
		b.high = h;
		b.low = l;
		b.close = c;
		bar_queue.push_back(b);
		bars_queued++;
	endfunction

	// Mostly plausible bars, plus raw noise and bars on or near high+low == 0
	function automatic bar_t random_bar();
		bar_t b;
		int unsigned base, up_part, dn_part;
		logic signed [PRICE_W-1:0] flip;
		int pick;
		pick = $urandom_range(0, 99);
		b.high = $urandom;
		b.low = $urandom;
		b.close = $urandom;
		if (pick < 65) begin
			base = ($urandom >> $urandom_range(2, 24)) + 1;
			up_part = $urandom_range(0, base >> $urandom_range(2, 10));
			dn_part = $urandom_range(0, base >> $urandom_range(2, 10));
			b.high = base + up_part;
			b.low = base - dn_part;
			b.close = b.low + $urandom_range(0, up_part + dn_part);
			if (pick < 8) begin
				flip = b.high;
				b.high = -b.low;
				b.low = -flip;
				b.close = -b.close;
			end
		end else if (pick < 88) begin
			b.low = -b.high;
		end else if (pick >= 80 && pick < 88) begin
			b.low = -b.high;
		end else if (pick >= 95) begin
			b.low = -b.high + int'($urandom_range(0, 4)) - 2;
		end
		return b;
	endfunction

	task automatic set_period(input logic [PERIOD_W-1:0] value);
		@(posedge clk);
		period_we <= 1'b1;
		period_wdata <= value;
		@(posedge clk);
		period_we <= 1'b0;
		// the write empties the window
		win_len = (value < PERIOD_MIN) ? PERIOD_MIN : (value > DEPTH) ? DEPTH : value;
		win_slot = 0;
		win_fill = 0;
		upper_acc = 0;
		middle_acc = 0;
		lower_acc = 0;
		settings_used++;
	endtask

	task automatic settle();
		while (bars_taken != bars_queued || band_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_window(sent_bar);
				bars_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (bar_queue.size() != 0) begin
					sent_bar = bar_queue.pop_front();
					bar_high <= sent_bar.high;
					bar_low <= sent_bar.low;
					bar_close <= sent_bar.close;
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 250)
								: $urandom_range(0, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: runs of open, held and jittering ready
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_run == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				stall_run = $urandom_range(1, 80);
			end else begin
				stall_run--;
			end
			case (stall_mode)
				RX_OPEN, RX_OPEN_LONG: out_ready <= 1'b1;
				RX_HOLD: out_ready <= 1'b0;
				default: out_ready <= $urandom_range(0, 1);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (band_queue.size() == 0) begin
				$display("%0t ns: unexpected band word, expected none, got %h %h %h",
						$time, upper_band, middle_band, lower_band);
				mismatches++;
			end else begin
				want_band = band_queue.pop_front();
				check_field("upper_band", want_band.upper, upper_band);
				check_field("middle_band", want_band.middle, middle_band);
				check_field("lower_band", want_band.lower, lower_band);
				bands_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [PERIOD_W-1:0] plan [8];
		plan = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd3, 7'd2, 7'd20};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset period
		repeat (45) begin
			bar_queue.push_back(random_bar());
			bars_queued++;
		end
		settle();

		// shortest window: nearly every bar yields a word
		set_period(7'd2);
		push_bar(32'sd0, 32'sd0, 32'sd0);
		push_bar(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
		push_bar(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		push_bar(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		push_bar(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		push_bar(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		push_bar(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		push_bar(32'sh0064_0000, -32'sh0064_0000, 32'sd0);
		push_bar(32'sh7FFF_FFFF, 32'sh8000_0001, 32'sh0001_0000);
		push_bar(32'sd1, 32'sd0, 32'sd1);
		push_bar(32'sh0001_0000, -32'sh0000_FFFF, 32'sd0);
		push_bar(-32'sd1, 32'sd0, -32'sd1);
		push_bar(32'sd1, -32'sd2, 32'sd0);
		push_bar(32'sh0069_8000, 32'sh0063_4000, 32'sh0066_0000);
		push_bar(-32'sh0032_0000, -32'sh003C_0000, -32'sh0037_0000);
		push_bar(32'sh000A_0000, 32'sh0014_0000, 32'sh000F_0000);
		push_bar(32'sh4000_0000, 32'sh3FFF_FFFF, 32'sh4000_0000);
		// close sums of -1 and +1 exercise the half-way rounding
		push_bar(32'sd0, 32'sd0, 32'sh7FFF_FFFF);
		push_bar(32'sd0, 32'sd0, 32'sh8000_0000);
		push_bar(32'sd0, 32'sd0, 32'sd1);
		push_bar(32'sd0, 32'sd0, 32'sd0);
		settle();

		for (int i = 0; i < 13; i++) begin
			set_period((i < 8) ? plan[i] : PERIOD_W'($urandom_range(2, DEPTH)));
			repeat (PHASE_BARS) begin
				bar_queue.push_back(random_bar());
				bars_queued++;
			end
			settle();
		end

		$display("summary: %0d bars sent, %0d band words checked, %0d period settings",
				bars_taken, bands_checked, settings_used);
		$display("summary: %0d mismatches over %0d cycles", mismatches, cycle_count);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
